@@ rtl/core/frks_pkg.sv @@
// ----------------------------------------------------------------------------
// frks_pkg: shared types and constants for the filtered random k sampler
// Register map indexes, sequencer state types and generator constants.
// ----------------------------------------------------------------------------
package frks_pkg;

  localparam int DEF_BUFFER_DEPTH = 1024;
  localparam int DEF_MAX_SAMPLE   = 64;

  localparam logic [63:0] PCG_MULT = 64'd6364136223846793005;

  localparam logic [2:0] REG_YEAR_LIMIT    = 3'd0;
  localparam logic [2:0] REG_SAMPLE_COUNT  = 3'd1;
  localparam logic [2:0] REG_NODE_LIMIT    = 3'd2;
  localparam logic [2:0] REG_RNG_SEED      = 3'd3;
  localparam logic [2:0] REG_RNG_INCREMENT = 3'd4;

  localparam logic [15:0] YEAR_LIMIT_RST = 16'hFFFF;
  localparam logic [6:0]  SAMPLE_CNT_RST = 7'd8;
  localparam logic [30:0] NODE_LIMIT_RST = 31'h7FFF_FFFF;
  localparam logic [62:0] RNG_INC_RST    = 63'd1442695040888963407;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_DECIDE,
    ST_PLAIN_RD,
    ST_PLAIN_OUT,
    ST_DRAW,
    ST_WAIT,
    ST_RDI,
    ST_RDJ,
    ST_SWAP,
    ST_OUT
  } smp_state_t;

  typedef enum logic [1:0] {
    DR_IDLE,
    DR_MUL,
    DR_ADD,
    DR_DIV
  } draw_phase_t;

endpackage

@@ rtl/core/filtered_random_k_sampler.sv @@
// ----------------------------------------------------------------------------
// filtered_random_k_sampler: filtered candidate buffer with random k-pick
// Buffers filtered node ids; picks k by a partial shuffle, or all if at most k.
// ----------------------------------------------------------------------------
// Usage:
//   Input: an id transfer happens on a rising edge with start high and busy
//   low. Ids are checked (non-negative, below node_limit, year at most
//   year_limit) and stored, one per cycle; busy stays low while loading.
//   The transfer with end_of_list high starts sampling; busy then rises.
//   Output: each pick shows for one cycle with result_strobe high. The
//   receiver cannot stall, so every pick must be taken when shown.
//   Results after the last id: for an empty list or a k of zero, a single
//   result marked empty_result. At most k kept: every kept id, in arrival
//   order. Otherwise, for each pick: launch the draw, step the generator on
//   the shared 32x32 multiplier plus an add, take the bit-serial remainder,
//   then read, swap and write back. busy falls after the result marked
//   last_pick. Config: APB writes at 8-byte steps, only while busy is low;
//   the user must keep to this, the block does not enforce it. A seed write
//   loads the generator state. Reset (rst, synchronous) clears the count,
//   the overflow flag and the generator state, and restores the registers.
// ----------------------------------------------------------------------------
module filtered_random_k_sampler #(
  parameter int BUFFER_DEPTH = frks_pkg::DEF_BUFFER_DEPTH,
  parameter int MAX_SAMPLE   = frks_pkg::DEF_MAX_SAMPLE
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] node_id,
  input  logic [15:0] node_year,
  input  logic        end_of_list,
  output logic        result_strobe,
  output logic [30:0] picked_id,
  output logic        last_pick,
  output logic        empty_result,
  output logic        buffer_overflow
);
  import frks_pkg::*;

  localparam int CW = $clog2(BUFFER_DEPTH + 1);
  localparam int AW = $clog2(BUFFER_DEPTH);
  localparam int KW = $clog2(MAX_SAMPLE + 1);

  // config registers
  logic [15:0] year_limit;
  logic [6:0]  sample_count;
  logic [30:0] node_limit;
  logic [62:0] rng_seed;
  logic [62:0] rng_increment;
  logic        cfg_wr;
  logic [2:0]  reg_idx;

  smp_state_t state, state_next;

  logic [CW-1:0] kept_count;
  logic          overflow_seen;
  logic [KW-1:0] i_idx;
  logic [AW-1:0] j_idx;
  logic [30:0]   vi, vj;

  // candidate buffer, one write and one registered read port
  logic [30:0]   mem [BUFFER_DEPTH];
  logic [30:0]   rd_data;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [30:0]   wr_data;

  logic          accept, keep, full;
  logic [KW-1:0] k_sat;
  logic          is_empty, n_le_k, finish;
  logic          last_plain, last_shuf;
  logic          draw_start, draw_done;
  logic [CW-1:0] span, draw_rem;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = paddr[5:3];

  always_comb begin
    unique case (reg_idx)
      REG_YEAR_LIMIT:    prdata = 64'(year_limit);
      REG_SAMPLE_COUNT:  prdata = 64'(sample_count);
      REG_NODE_LIMIT:    prdata = 64'(node_limit);
      REG_RNG_SEED:      prdata = 64'(rng_seed);
      REG_RNG_INCREMENT: prdata = 64'(rng_increment);
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      year_limit    <= YEAR_LIMIT_RST;
      sample_count  <= SAMPLE_CNT_RST;
      node_limit    <= NODE_LIMIT_RST;
      rng_seed      <= '0;
      rng_increment <= RNG_INC_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_YEAR_LIMIT:    year_limit    <= pwdata[15:0];
        REG_SAMPLE_COUNT:  sample_count  <= pwdata[6:0];
        REG_NODE_LIMIT:    node_limit    <= pwdata[30:0];
        REG_RNG_SEED:      rng_seed      <= pwdata[62:0];
        REG_RNG_INCREMENT: rng_increment <= pwdata[62:0];
        default: ;
      endcase
    end
  end

  // filter on transfer: sign bit clear, id below limit, year in range
  always_comb begin
    accept = start && !busy;
    keep   = !node_id[31] && (node_id[30:0] < node_limit) && (node_year <= year_limit);
    full   = (32'(kept_count) == BUFFER_DEPTH);
  end

  always_comb begin
    k_sat      = (32'(sample_count) > MAX_SAMPLE) ? KW'(MAX_SAMPLE) : KW'(sample_count);
    is_empty   = (kept_count == '0) || (k_sat == '0);
    n_le_k     = (32'(kept_count) <= 32'(k_sat));
    last_plain = (32'(i_idx) + 1 == 32'(kept_count));
    last_shuf  = (i_idx + KW'(1) == k_sat);
    span       = kept_count - CW'(i_idx);
  end

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD:      if (accept && end_of_list) state_next = ST_DECIDE;
      ST_DECIDE: begin
        if (is_empty)    state_next = ST_LOAD;
        else if (n_le_k) state_next = ST_PLAIN_RD;
        else             state_next = ST_DRAW;
      end
      ST_PLAIN_RD:  state_next = ST_PLAIN_OUT;
      ST_PLAIN_OUT: state_next = last_plain ? ST_LOAD : ST_PLAIN_RD;
      ST_DRAW:      state_next = ST_WAIT;
      ST_WAIT:      if (draw_done) state_next = ST_RDI;
      ST_RDI:       state_next = ST_RDJ;
      ST_RDJ:       state_next = ST_SWAP;
      ST_SWAP:      state_next = ST_OUT;
      ST_OUT:       state_next = last_shuf ? ST_LOAD : ST_DRAW;
      default:      state_next = ST_LOAD;
    endcase
  end

  // outputs and buffer port control
  always_comb begin
    busy          = (state != ST_LOAD);
    result_strobe = 1'b0;
    picked_id     = '0;
    last_pick     = 1'b0;
    empty_result  = 1'b0;
    finish        = 1'b0;
    draw_start    = 1'b0;
    wr_en         = 1'b0;
    wr_addr       = AW'(kept_count);
    wr_data       = node_id[30:0];
    rd_addr       = AW'(i_idx);
    unique case (state)
      ST_LOAD: wr_en = accept && keep && !full;
      ST_DECIDE: begin
        if (is_empty) begin
          result_strobe = 1'b1;
          last_pick     = 1'b1;
          empty_result  = 1'b1;
          finish        = 1'b1;
        end
      end
      ST_PLAIN_OUT: begin
        result_strobe = 1'b1;
        picked_id     = rd_data;
        last_pick     = last_plain;
        finish        = last_plain;
      end
      ST_DRAW: draw_start = 1'b1;
      ST_RDJ:  rd_addr = j_idx;
      ST_SWAP: begin
        wr_en   = 1'b1;
        wr_addr = AW'(i_idx);
        wr_data = rd_data;
      end
      ST_OUT: begin
        wr_en         = 1'b1;
        wr_addr       = j_idx;
        wr_data       = vi;
        result_strobe = 1'b1;
        picked_id     = vj;
        last_pick     = last_shuf;
        finish        = last_shuf;
      end
      default: ;
    endcase
    buffer_overflow = overflow_seen;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_LOAD;
      kept_count    <= '0;
      overflow_seen <= 1'b0;
      i_idx         <= '0;
    end else begin
      state <= state_next;
      if (state == ST_LOAD && accept && keep) begin
        if (full) overflow_seen <= 1'b1;
        else      kept_count    <= kept_count + CW'(1);
      end
      if (state == ST_DECIDE) i_idx <= '0;
      if (state == ST_PLAIN_OUT || state == ST_OUT) i_idx <= i_idx + KW'(1);
      if (finish) begin
        kept_count    <= '0;
        overflow_seen <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_WAIT && draw_done) j_idx <= AW'(CW'(i_idx) + draw_rem);
    if (state == ST_RDJ)  vi <= rd_data;
    if (state == ST_SWAP) vj <= rd_data;
  end

  frks_draw #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) u_draw (
    .clk      (clk),
    .rst      (rst),
    .seed_load(cfg_wr && (reg_idx == REG_RNG_SEED)),
    .seed     (pwdata[62:0]),
    .incr     (rng_increment),
    .start    (draw_start),
    .span     (span),
    .done     (draw_done),
    .rem_out  (draw_rem)
  );

`ifndef SYNTH
  a_strobe_busy: assert property (@(posedge clk) disable iff (rst)
    result_strobe |-> busy)
    else $error("result outside sampling");
  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && empty_result) |-> last_pick)
    else $error("empty result not last");
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && last_pick) |=> (!busy && kept_count == '0))
    else $error("block not idle after last pick");
`endif

endmodule

@@ rtl/core/frks_draw.sv @@
// ----------------------------------------------------------------------------
// frks_draw: PCG-XSH-RR 64/32 draw reduced modulo a span
// One shared 32x32 multiplier steps the LCG, a bit-serial unit takes the mod.
// ----------------------------------------------------------------------------
module frks_draw #(
  parameter int BUFFER_DEPTH = frks_pkg::DEF_BUFFER_DEPTH
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                seed_load,
  input  logic [62:0]                         seed,
  input  logic [62:0]                         incr,
  input  logic                                start,
  input  logic [$clog2(BUFFER_DEPTH+1)-1:0]   span,
  output logic                                done,
  output logic [$clog2(BUFFER_DEPTH+1)-1:0]   rem_out
);
  import frks_pkg::*;

  localparam int CW = $clog2(BUFFER_DEPTH + 1);

  draw_phase_t phase, phase_next;
  logic [63:0]   gen_state;
  logic [63:0]   acc;
  logic [63:0]   prod;
  logic [31:0]   xr;
  logic [CW-1:0] rem;
  logic [CW-1:0] span_r;
  logic [4:0]    cnt;
  logic [31:0]   mul_a, mul_b;
  logic [31:0]   pcg_x;
  logic [63:0]   pcg_rot;
  logic [CW:0]   trial;
  logic [CW-1:0] rem_step;

  // XSH-RR output of the current state
  always_comb begin
    pcg_x   = 32'(((gen_state >> 18) ^ gen_state) >> 27);
    pcg_rot = {pcg_x, pcg_x} >> gen_state[63:59];
  end

  always_comb begin
    unique case (cnt[1:0])
      2'd0:    begin mul_a = gen_state[31:0];  mul_b = PCG_MULT[31:0];  end
      2'd1:    begin mul_a = gen_state[31:0];  mul_b = PCG_MULT[63:32]; end
      2'd2:    begin mul_a = gen_state[63:32]; mul_b = PCG_MULT[31:0];  end
      default: begin mul_a = gen_state[31:0];  mul_b = PCG_MULT[31:0];  end
    endcase
  end

  // restoring remainder step, one dividend bit per cycle
  always_comb begin
    trial    = {rem, xr[31]};
    rem_step = (trial >= {1'b0, span_r}) ? CW'(trial - {1'b0, span_r}) : CW'(trial);
  end

  always_comb begin
    phase_next = phase;
    unique case (phase)
      DR_IDLE: if (start) phase_next = DR_MUL;
      DR_MUL:  if (cnt == 5'd3) phase_next = DR_ADD;
      DR_ADD:  phase_next = DR_DIV;
      DR_DIV:  if (cnt == 5'd31) phase_next = DR_IDLE;
      default: phase_next = DR_IDLE;
    endcase
  end

  always_comb begin
    done    = (phase == DR_DIV) && (cnt == 5'd31);
    rem_out = rem_step;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= DR_IDLE;
      gen_state <= '0;
      cnt       <= '0;
    end else begin
      phase <= phase_next;
      if (seed_load) begin
        gen_state <= {1'b0, seed};
      end
      unique case (phase)
        DR_IDLE: begin
          if (start) begin
            xr     <= pcg_rot[31:0];
            rem    <= '0;
            span_r <= span;
            cnt    <= '0;
          end
        end
        DR_MUL: begin
          prod <= 64'(mul_a) * 64'(mul_b);
          cnt  <= cnt + 5'd1;
          if (cnt == 5'd1) begin
            acc <= prod;
          end else if (cnt != 5'd0) begin
            acc[63:32] <= acc[63:32] + prod[31:0];
          end
        end
        DR_ADD: begin
          gen_state <= acc + {1'b0, incr[62:1], 1'b1};
          cnt       <= '0;
        end
        DR_DIV: begin
          rem <= rem_step;
          xr  <= {xr[30:0], 1'b0};
          cnt <= cnt + 5'd1;
        end
        default: ;
      endcase
    end
  end

endmodule
